// ===== src/srb_pkg.sv =====
// Shared types and constants of the SPI master register block.
// Used by srb_front, srb_back, spi_master_register_block, srb_checker and testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

   localparam int RING_DEPTH_DEFAULT   = 256;
   localparam int SELECT_LINES_DEFAULT = 16;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [12:0] DATA_LO_ADDR   = 13'h0060;
   localparam logic [12:0] DATA_HI_ADDR   = 13'h00ec;
   localparam logic [12:0] VENDOR_ADDR    = 13'h00f0;
   localparam logic [12:0] DATA_FIFO_ADDR = 13'h1000;

   localparam logic [1:0] FAULT_OK       = 2'd0;
   localparam logic [1:0] FAULT_UNIMPL   = 2'd1;
   localparam logic [1:0] FAULT_EEPROM   = 2'd2;
   localparam logic [1:0] FAULT_OVERFLOW = 2'd3;

   localparam logic [1:0] MODE_TXRX   = 2'd0;
   localparam logic [1:0] MODE_TX     = 2'd1;
   localparam logic [1:0] MODE_RX     = 2'd2;
   localparam logic [1:0] MODE_EEPROM = 2'd3;

   localparam logic [31:0] CTRL0_RESET  = 32'h0000_0007;
   localparam logic [31:0] STATUS_VALUE = 32'h0000_0006;
   localparam logic [7:0]  IDLE_BYTE    = 8'hff;

   typedef enum logic [1:0] {
      CL_REG    = 2'd0,
      CL_DATA   = 2'd1,
      CL_VENDOR = 2'd2
   } class_type;

   typedef enum logic [3:0] {
      RC_CTRL0   = 4'd0,
      RC_CTRL1   = 4'd1,
      RC_ENABLE  = 4'd2,
      RC_MWCR    = 4'd3,
      RC_SER     = 4'd4,
      RC_BAUD    = 4'd5,
      RC_TXFTL   = 4'd6,
      RC_RXFTL   = 4'd7,
      RC_TXFLR   = 4'd8,
      RC_RXFLR   = 4'd9,
      RC_SR      = 4'd10,
      RC_IMR     = 4'd11,
      RC_DMACR   = 4'd12,
      RC_DMARDLR = 4'd13,
      RC_NONE    = 4'd14
   } reg_code_type;

   typedef struct packed {
      logic         func;
      class_type    cls;
      reg_code_type code;
      logic [31:0]  write_data;
      logic [2:0]   nbytes;
      logic [31:0]  spi_reply;
   } item_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_EXEC    = 5'b00010,
      ST_RD_WAIT = 5'b00100,
      ST_RD_BYTE = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ===== src/srb_front.sv =====
// Front end: takes bus requests, decodes the address and queues decoded items.
// Depends on srb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srb_front import srb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [14:0] req_address,
   input  wire logic [31:0] req_write_data,
   input  wire logic [2:0]  req_access_size,
   input  wire logic [31:0] req_spi_reply,
   output logic             q_valid,
   input  wire logic        q_pop,
   output item_type         q_item
);

   item_type    q_mem_ff [QUEUE_DEPTH];
   logic        wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [12:0] addr;
   item_type    dec;
   logic        push;

   assign addr      = req_address[12:0];
   assign req_stall = (cnt_ff == 2'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = q_mem_ff[rptr_ff];

   always_comb begin
      dec.func       = req_func;
      dec.write_data = req_write_data;
      dec.spi_reply  = req_spi_reply;
      dec.nbytes     = (req_access_size > 3'd4) ? 3'd4 : req_access_size;
      dec.code       = RC_NONE;
      if ((addr >= DATA_LO_ADDR && addr <= DATA_HI_ADDR) || addr >= DATA_FIFO_ADDR) begin
         dec.cls = CL_DATA;
      end else if (addr >= VENDOR_ADDR) begin
         dec.cls = CL_VENDOR;
      end else begin
         dec.cls = CL_REG;
         unique case (addr[7:0])
            8'h00:   dec.code = RC_CTRL0;
            8'h04:   dec.code = RC_CTRL1;
            8'h08:   dec.code = RC_ENABLE;
            8'h0c:   dec.code = RC_MWCR;
            8'h10:   dec.code = RC_SER;
            8'h14:   dec.code = RC_BAUD;
            8'h18:   dec.code = RC_TXFTL;
            8'h1c:   dec.code = RC_RXFTL;
            8'h20:   dec.code = RC_TXFLR;
            8'h24:   dec.code = RC_RXFLR;
            8'h28:   dec.code = RC_SR;
            8'h2c:   dec.code = RC_IMR;
            8'h4c:   dec.code = RC_DMACR;
            8'h54:   dec.code = RC_DMARDLR;
            default: dec.code = RC_NONE;
         endcase
      end
   end

   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = q_pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wptr_ff] <= dec;
      end
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/srb_back.sv =====
// Back end: register file, receive ring, read sequencer and response register.
// Depends on srb_pkg; fed by srb_front.
`timescale 1ns / 1ps
`default_nettype none

module srb_back import srb_pkg::*; #(
   parameter int RING_DEPTH   = RING_DEPTH_DEFAULT,
   parameter int SELECT_LINES = SELECT_LINES_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   output logic                         q_pop,
   input  wire item_type                q_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [31:0]                  rsp_read_data,
   output logic [2:0]                   rsp_sent_count,
   output logic [31:0]                  rsp_sent_bytes,
   output logic [SELECT_LINES-1:0]      rsp_select_lines_n,
   output logic [1:0]                   rsp_fault
);

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int SW = CW + 1;

   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] rdata_ff;
   logic       ring_we;
   logic [AW-1:0] ring_waddr;

   state_type  state_ff, state_in;
   item_type   cur_ff, cur_in;
   logic [31:0] acc_ff, acc_in, sent_ff, sent_in;
   logic [2:0]  nsent_ff, nsent_in;
   logic [1:0]  fault_ff, fault_in, bidx_ff, bidx_in;

   logic [31:0] ctrl0_ff, ctrl0_in, mwcr_ff, mwcr_in, ser_ff, ser_in;
   logic [31:0] baud_ff, baud_in, txftl_ff, txftl_in, rxftl_ff, rxftl_in;
   logic [31:0] dmacr_ff, dmacr_in, dmardlr_ff, dmardlr_in, imr_ff, imr_in;
   logic [15:0] ctrl1_ff, ctrl1_in;
   logic        enable_ff, enable_in, chosen_ff, chosen_in;
   logic [SELECT_LINES-1:0] sel_ff, sel_in, sel_choice;
   logic [16:0] pending_ff, pending_in;
   logic [AW-1:0] head_ff, head_in, head_next;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]  held_ff, held_in;
   logic        held_v_ff, held_v_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_rd_ff, rsp_rd_in, rsp_sent_ff, rsp_sent_in;
   logic [2:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [SELECT_LINES-1:0] rsp_sel_ff, rsp_sel_in;
   logic [1:0]  rsp_fault_ff, rsp_fault_in;

   logic [31:0] choose_src, low_bit;
   logic [SW-1:0] tail_sum;
   logic [7:0]  byte_v, reply_b;
   logic        took_ring;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_rd_ff;
   assign rsp_sent_count     = rsp_cnt_ff;
   assign rsp_sent_bytes     = rsp_sent_ff;
   assign rsp_select_lines_n = rsp_sel_ff;
   assign rsp_fault          = rsp_fault_ff;

   // Selection picks the lowest set enable bit; a bit beyond the lines drops none.
   assign choose_src = (cur_ff.cls == CL_DATA) ? ser_ff : cur_ff.write_data;
   assign low_bit    = choose_src & (~choose_src + 32'd1);
   assign sel_choice = ~low_bit[SELECT_LINES-1:0];

   assign tail_sum   = SW'(head_ff) + SW'(count_ff);
   assign ring_waddr = (tail_sum >= SW'(RING_DEPTH)) ? AW'(tail_sum - SW'(RING_DEPTH))
                                                     : AW'(tail_sum);
   assign head_next  = (SW'(head_ff) + SW'(1) == SW'(RING_DEPTH)) ? '0 : head_ff + AW'(1);
   assign reply_b    = cur_ff.spi_reply[{nsent_ff[1:0], 3'b000} +: 8];

   always_comb begin
      state_in = state_ff;  cur_in = cur_ff;   acc_in = acc_ff;
      sent_in = sent_ff;    nsent_in = nsent_ff; fault_in = fault_ff;
      bidx_in = bidx_ff;
      ctrl0_in = ctrl0_ff;  ctrl1_in = ctrl1_ff; enable_in = enable_ff;
      mwcr_in = mwcr_ff;    ser_in = ser_ff;     baud_in = baud_ff;
      txftl_in = txftl_ff;  rxftl_in = rxftl_ff; dmacr_in = dmacr_ff;
      dmardlr_in = dmardlr_ff; imr_in = imr_ff;  chosen_in = chosen_ff;
      sel_in = sel_ff;      pending_in = pending_ff;
      head_in = head_ff;    count_in = count_ff;
      held_in = held_ff;    held_v_in = held_v_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rd_in = rsp_rd_ff; rsp_sent_in = rsp_sent_ff; rsp_cnt_in = rsp_cnt_ff;
      rsp_sel_in = rsp_sel_ff; rsp_fault_in = rsp_fault_ff;
      q_pop = 1'b0;  ring_we = 1'b0;
      byte_v = IDLE_BYTE;  took_ring = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               acc_in   = '0;
               sent_in  = '0;
               nsent_in = '0;
               fault_in = FAULT_OK;
               bidx_in  = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            if (cur_ff.cls == CL_DATA) begin
               if (!cur_ff.func) begin
                  if (cur_ff.nbytes != 3'd0) state_in = ST_RD_WAIT;
               end else begin
                  if (!chosen_ff) begin
                     sel_in    = sel_choice;
                     chosen_in = (ser_ff != '0);
                     if (ser_ff == '0) held_v_in = 1'b0;
                  end
                  unique case (ctrl0_ff[9:8])
                     MODE_TXRX: begin
                        nsent_in = 3'd1;
                        sent_in  = {24'd0, cur_ff.write_data[7:0]};
                        if (count_ff >= CW'(RING_DEPTH)) begin
                           fault_in = FAULT_OVERFLOW;
                        end else begin
                           ring_we  = 1'b1;
                           count_in = count_ff + CW'(1);
                        end
                     end
                     MODE_TX: begin
                        nsent_in  = 3'd1;
                        sent_in   = {24'd0, cur_ff.write_data[7:0]};
                        held_in   = cur_ff.spi_reply[7:0];
                        held_v_in = 1'b1;
                     end
                     MODE_RX: begin
                        if (pending_ff == '0) pending_in = 17'(ctrl1_ff) + 17'd1;
                     end
                     MODE_EEPROM: fault_in = FAULT_EEPROM;
                  endcase
               end
            end else if (cur_ff.cls == CL_REG) begin
               if (cur_ff.func) begin
                  unique case (cur_ff.code)
                     RC_CTRL0:   ctrl0_in = cur_ff.write_data;
                     RC_CTRL1:   ctrl1_in = cur_ff.write_data[15:0];
                     RC_ENABLE: begin
                        enable_in = cur_ff.write_data[0];
                        if (!cur_ff.write_data[0]) begin
                           head_in = '0; count_in = '0; pending_in = '0;
                        end
                     end
                     RC_MWCR:    mwcr_in = cur_ff.write_data;
                     RC_SER: begin
                        ser_in    = cur_ff.write_data;
                        sel_in    = sel_choice;
                        chosen_in = (cur_ff.write_data != '0);
                        if (cur_ff.write_data == '0) held_v_in = 1'b0;
                     end
                     RC_BAUD:    baud_in = cur_ff.write_data;
                     RC_TXFTL:   txftl_in = cur_ff.write_data;
                     RC_RXFTL:   rxftl_in = cur_ff.write_data;
                     RC_IMR:     imr_in = cur_ff.write_data;
                     RC_DMACR:   dmacr_in = cur_ff.write_data;
                     RC_DMARDLR: dmardlr_in = cur_ff.write_data;
                     default:    fault_in = FAULT_UNIMPL;
                  endcase
               end else begin
                  unique case (cur_ff.code)
                     RC_CTRL0:   acc_in = ctrl0_ff;
                     RC_CTRL1:   acc_in = 32'(ctrl1_ff);
                     RC_ENABLE:  acc_in = 32'(enable_ff);
                     RC_MWCR:    acc_in = mwcr_ff;
                     RC_SER:     acc_in = ser_ff;
                     RC_BAUD:    acc_in = baud_ff;
                     RC_TXFTL:   acc_in = txftl_ff;
                     RC_RXFTL:   acc_in = rxftl_ff;
                     RC_TXFLR:   acc_in = '0;
                     RC_RXFLR:   acc_in = 32'(count_ff) + 32'(pending_ff);
                     RC_SR:      acc_in = STATUS_VALUE;
                     RC_IMR:     acc_in = imr_ff;
                     RC_DMACR:   acc_in = dmacr_ff;
                     default:    fault_in = FAULT_UNIMPL;
                  endcase
               end
            end
         end
         ST_RD_WAIT: state_in = ST_RD_BYTE;
         ST_RD_BYTE: begin
            if (held_v_ff) begin
               byte_v    = held_ff;
               held_v_in = 1'b0;
            end else if (count_ff != '0) begin
               byte_v    = rdata_ff;
               head_in   = head_next;
               count_in  = count_ff - CW'(1);
               took_ring = 1'b1;
            end else if (chosen_ff) begin
               byte_v   = reply_b;
               sent_in[{nsent_ff[1:0], 3'b000} +: 8] = IDLE_BYTE;
               nsent_in = nsent_ff + 3'd1;
               if (pending_ff != '0) pending_in = pending_ff - 17'd1;
            end
            acc_in[{bidx_ff, 3'b000} +: 8] = byte_v;
            bidx_in = bidx_ff + 2'd1;
            // The ring read port is registered, so after a ring byte the sequencer refetches via ST_RD_WAIT.
            if ({1'b0, bidx_ff} + 3'd1 == cur_ff.nbytes) state_in = ST_DONE;
            else if (took_ring) state_in = ST_RD_WAIT;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = acc_ff;
               rsp_sent_in  = sent_ff;
               rsp_cnt_in   = nsent_ff;
               rsp_sel_in   = sel_ff;
               rsp_fault_in = fault_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[ring_waddr] <= cur_ff.spi_reply[7:0];
      rdata_ff <= ring_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;   acc_ff <= acc_in;   sent_ff <= sent_in;
      nsent_ff <= nsent_in; fault_ff <= fault_in; bidx_ff <= bidx_in;
      rsp_rd_ff <= rsp_rd_in; rsp_sent_ff <= rsp_sent_in; rsp_cnt_ff <= rsp_cnt_in;
      rsp_sel_ff <= rsp_sel_in; rsp_fault_ff <= rsp_fault_in;
      if (reset) begin
         state_ff <= ST_IDLE;   rsp_valid_ff <= 1'b0;
         ctrl0_ff <= CTRL0_RESET; ctrl1_ff <= '0; enable_ff <= 1'b0;
         mwcr_ff <= '0; ser_ff <= '0; baud_ff <= '0; txftl_ff <= '0;
         rxftl_ff <= '0; dmacr_ff <= '0; dmardlr_ff <= '0; imr_ff <= '0;
         chosen_ff <= 1'b0; sel_ff <= '1; pending_ff <= '0;
         head_ff <= '0; count_ff <= '0; held_ff <= '0; held_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  rsp_valid_ff <= rsp_valid_in;
         ctrl0_ff <= ctrl0_in; ctrl1_ff <= ctrl1_in; enable_ff <= enable_in;
         mwcr_ff <= mwcr_in; ser_ff <= ser_in; baud_ff <= baud_in; txftl_ff <= txftl_in;
         rxftl_ff <= rxftl_in; dmacr_ff <= dmacr_in; dmardlr_ff <= dmardlr_in;
         imr_ff <= imr_in; chosen_ff <= chosen_in; sel_ff <= sel_in;
         pending_ff <= pending_in; head_ff <= head_in; count_ff <= count_in;
         held_ff <= held_in; held_v_ff <= held_v_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/spi_master_register_block.sv =====
// Top level of the SPI master register block: decode front end and execute back end.
// Depends on srb_pkg, srb_front and srb_back.
//
//   port group   direction  handshake           carries
//   req_*        in         req_valid/req_stall one bus request
//   rsp_*        out        rsp_valid/rsp_stall one response per request
//
// Register accesses and data writes pass through ST_EXEC and ST_DONE to the response
// register; a data read also passes ST_RD_BYTE once per byte, with ST_RD_WAIT before it
// and after each ring byte followed by another byte, as the ring read is registered.
// The front queue holds two requests, so requests are taken while a response is stalled.
// Reset is synchronous; the receive ring contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module spi_master_register_block import srb_pkg::*; #(
   parameter int RING_DEPTH   = RING_DEPTH_DEFAULT,
   parameter int SELECT_LINES = SELECT_LINES_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_func,
   input  wire logic [14:0]             req_address,
   input  wire logic [31:0]             req_write_data,
   input  wire logic [2:0]              req_access_size,
   input  wire logic [31:0]             req_spi_reply,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [31:0]                  rsp_read_data,
   output logic [2:0]                   rsp_sent_count,
   output logic [31:0]                  rsp_sent_bytes,
   output logic [SELECT_LINES-1:0]      rsp_select_lines_n,
   output logic [1:0]                   rsp_fault
);

   logic     q_valid, q_pop;
   item_type q_item;

   srb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_access_size (req_access_size),
      .req_spi_reply   (req_spi_reply),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_item          (q_item)
   );

   srb_back #(
      .RING_DEPTH   (RING_DEPTH),
      .SELECT_LINES (SELECT_LINES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .q_item             (q_item),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_sent_count     (rsp_sent_count),
      .rsp_sent_bytes     (rsp_sent_bytes),
      .rsp_select_lines_n (rsp_select_lines_n),
      .rsp_fault          (rsp_fault)
   );

   a_sent_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sent_count <= 3'd4)
      else $error("more than four transfers in one response");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fault != FAULT_OK) |-> rsp_read_data == 32'd0)
      else $error("faulting access returned data");

   a_one_select: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(~rsp_select_lines_n) <= 1)
      else $error("more than one chip select asserted");

   a_queue_hold: assert property (@(posedge clock) disable iff (reset)
      (q_valid && !q_pop) |=> q_valid)
      else $error("queued request lost without being taken");

endmodule

`default_nettype wire

// ===== dv/srb_checker.sv =====
// Checker for the SPI master register block: watches both channels, predicts each response.
// Depends on srb_pkg for the fault and transfer mode codes and the reset and status values.
`timescale 1ns / 1ps

module srb_checker import srb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_func,
   input  wire logic [14:0] req_address,
   input  wire logic [31:0] req_write_data,
   input  wire logic [2:0]  req_access_size,
   input  wire logic [31:0] req_spi_reply,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [31:0] rsp_read_data,
   input  wire logic [2:0]  rsp_sent_count,
   input  wire logic [31:0] rsp_sent_bytes,
   input  wire logic [15:0] rsp_select_lines_n,
   input  wire logic [1:0]  rsp_fault,
   output int               error_count,
   output int               responses_due
);

   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  sent_count;
      logic [31:0] sent_bytes;
      logic [15:0] select_n;
      logic [1:0]  fault;
   } response_type;

   response_type expected_responses[$];

   logic [31:0] ctrl0, mwcr, ser, baud, txftl, rxftl, dmacr, dmardlr, imr;
   logic [15:0] ctrl1;
   logic        enable, chosen, held_valid;
   logic [15:0] lines;
   logic [16:0] pending;
   logic [7:0]  ring[256];
   logic [7:0]  head, held;
   logic [8:0]  count;
   int          xfer_n;
   logic [31:0] xfer_out, xfer_reply;

   function automatic logic [7:0] shift_byte(input logic [7:0] b);
      logic [7:0] r;
      xfer_out[8*xfer_n +: 8] = b;
      r = xfer_reply[8*xfer_n +: 8];
      xfer_n++;
      return r;
   endfunction

   function automatic void reselect();
      int i;
      lines = 16'hffff;
      if (ser == 0) begin
         held_valid = 0;
         chosen = 0;
         return;
      end
      i = 0;
      while (i < 31 && !ser[i]) i++;
      chosen = 1;
      if (i < 16) lines[i] = 1'b0;
   endfunction

   function automatic response_type predict_access(input logic wr, input logic [14:0] a15,
         input logic [31:0] val, input logic [2:0] size_in, input logic [31:0] reply);
      response_type r;
      logic [12:0] a;
      logic [7:0] b;
      int n;
      r = '0;
      a = a15[12:0];
      xfer_n = 0;
      xfer_out = 0;
      xfer_reply = reply;
      if ((a >= 13'h60 && a <= 13'hec) || a >= 13'h1000) begin
         if (wr) begin
            if (!chosen) reselect();
            case (ctrl0[9:8])
               MODE_TXRX: begin
                  b = shift_byte(val[7:0]);
                  if (count >= 256) r.fault = FAULT_OVERFLOW;
                  else begin
                     ring[head + count[7:0]] = b;
                     count++;
                  end
               end
               MODE_RX: if (pending == 0) pending = {1'b0, ctrl1} + 17'd1;
               MODE_TX: begin
                  held = shift_byte(val[7:0]);
                  held_valid = 1;
               end
               default: r.fault = FAULT_EEPROM;
            endcase
         end else begin
            n = size_in > 4 ? 4 : size_in;
            for (int i = 0; i < n; i++) begin
               if (held_valid) begin
                  b = held;
                  held_valid = 0;
               end else if (count != 0) begin
                  b = ring[head];
                  head++;
                  count--;
               end else if (chosen) begin
                  b = shift_byte(8'hff);
                  if (pending != 0) pending--;
               end else b = 8'hff;
               r.read_data[8*i +: 8] = b;
            end
         end
      end else if (a >= 13'hf0) begin
         // vendor area: nothing kept, no fault
      end else if (wr) begin
         case (a)
            13'h00: ctrl0 = val;
            13'h04: ctrl1 = val[15:0];
            13'h08: begin
               enable = val[0];
               if (!val[0]) begin
                  head = 0;
                  count = 0;
                  pending = 0;
               end
            end
            13'h0c: mwcr = val;
            13'h10: begin
               ser = val;
               reselect();
            end
            13'h14: baud = val;
            13'h18: txftl = val;
            13'h1c: rxftl = val;
            13'h2c: imr = val;
            13'h4c: dmacr = val;
            13'h54: dmardlr = val;
            default: r.fault = FAULT_UNIMPL;
         endcase
      end else begin
         case (a)
            13'h00: r.read_data = ctrl0;
            13'h04: r.read_data = {16'h0, ctrl1};
            13'h08: r.read_data = {31'h0, enable};
            13'h0c: r.read_data = mwcr;
            13'h10: r.read_data = ser;
            13'h14: r.read_data = baud;
            13'h18: r.read_data = txftl;
            13'h1c: r.read_data = rxftl;
            13'h20: r.read_data = 0;
            13'h24: r.read_data = 32'(count) + 32'(pending);
            13'h28: r.read_data = STATUS_VALUE;
            13'h2c: r.read_data = imr;
            13'h4c: r.read_data = dmacr;
            default: r.fault = FAULT_UNIMPL;
         endcase
      end
      r.sent_count = 3'(xfer_n);
      r.sent_bytes = xfer_out;
      r.select_n = lines;
      return r;
   endfunction

   assign responses_due = expected_responses.size();

   always @(posedge clock) begin
      response_type got, want;
      if (reset) begin
         ctrl0 <= CTRL0_RESET;
         {ctrl1, enable, mwcr, ser, baud, txftl, rxftl, dmacr, dmardlr, imr} <= '0;
         chosen <= 0;
         lines <= 16'hffff;
         pending <= 0;
         head <= 0;
         count <= 0;
         held <= 0;
         held_valid <= 0;
         error_count <= 0;
         expected_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_read_data, rsp_sent_count, rsp_sent_bytes, rsp_select_lines_n,
                    rsp_fault};
            if (expected_responses.size() == 0) begin
               if (error_count < 10) $display("Unexpected response %h", got);
               error_count <= error_count + 1;
            end else begin
               want = expected_responses.pop_front();
               if (got !== want) begin
                  if (error_count < 10)
                     $display("Mismatch: read %h/%h count %0d/%0d sent %h/%h sel %h/%h fault %0d/%0d",
                        want.read_data, got.read_data, want.sent_count, got.sent_count,
                        want.sent_bytes, got.sent_bytes, want.select_n, got.select_n,
                        want.fault, got.fault);
                  error_count <= error_count + 1;
               end
            end
         end
         // Blocking state updates inside the predictor are fine: the checker owns this state.
         if (req_valid && !req_stall)
            expected_responses.push_back(predict_access(req_func, req_address, req_write_data,
               req_access_size, req_spi_reply));
      end
   end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the SPI master register block; srb_checker does the predicting.
// Depends on srb_pkg, srb_checker and spi_master_register_block.
`timescale 1ns / 1ps

module testbench;
   import srb_pkg::*;

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, req_func = 0, rsp_stall = 0;
   logic [14:0] req_address = 0;
   logic [31:0] req_write_data = 0, req_spi_reply = 0;
   logic [2:0]  req_access_size = 0;
   logic        req_stall, rsp_valid;
   logic [31:0] rsp_read_data, rsp_sent_bytes;
   logic [2:0]  rsp_sent_count;
   logic [15:0] rsp_select_lines_n;
   logic [1:0]  rsp_fault;
   int          error_count, responses_due, idle_cycles;
   bit          hold_off = 0, stimulus_done = 0;

   always #5 clock = ~clock;

   spi_master_register_block u_dut (.*);

   srb_checker u_checker (.*);

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   // Valid stays high after acceptance; the caller drops it before any idle cycles.
   task automatic send_request(input logic wr, input logic [14:0] a, input logic [31:0] d,
         input logic [2:0] sz);
      req_valid <= 1;
      req_func <= wr;
      req_address <= a;
      req_write_data <= d;
      req_access_size <= sz;
      req_spi_reply <= $urandom;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_gap();
      int n;
      n = $urandom_range(0, 2) == 0 ? gap_length() : 0;
      if (n > 0) req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [14:0] data_address();
      case ($urandom_range(0, 2))
         0: return 15'h60 + 15'($urandom_range(0, 35) * 4);
         1: return 15'h1000 + 15'($urandom_range(0, 4095));
         default: return 15'($urandom_range(0, 3)) * 15'h2000 + 15'h1000
                  + 15'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic random_access();
      logic [14:0] regs[15];
      logic [31:0] d;
      int k;
      regs = '{15'h00, 15'h04, 15'h08, 15'h0c, 15'h10, 15'h14, 15'h18, 15'h1c, 15'h20,
               15'h24, 15'h28, 15'h2c, 15'h4c, 15'h54, 15'h30};
      k = $urandom_range(0, 19);
      if (k < 8) send_request(0, data_address(), $urandom, 3'($urandom_range(0, 7)));
      else if (k < 13) send_request(1, data_address(), $urandom, 3'($urandom));
      else if (k == 13) begin
         // Mostly sensible modes and small frame counts keep data traffic interesting.
         d = $urandom;
         d[9:8] = $urandom_range(0, 9) == 0 ? MODE_EEPROM : 2'($urandom_range(0, 2));
         send_request(1, 15'h00, d, 3'd4);
      end else if (k == 14) begin
         d = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 1)) << $urandom_range(0, 31)
            : $urandom;
         send_request(1, 15'h10, d, 3'd4);
      end else if (k == 15) send_request(1, 15'h08, 32'($urandom_range(0, 5) != 0), 3'd4);
      else if (k == 16) send_request(1, 15'h04, $urandom & 32'h8000_000f, 3'd4);
      else if (k == 17) send_request($urandom_range(0, 1), 15'($urandom), $urandom, 3'($urandom));
      else send_request($urandom_range(0, 1), regs[$urandom_range(0, 14)] |
         15'($urandom_range(0, 3)) * 15'h2000, $urandom, 3'($urandom));
   endtask

   // Receiver side: random stalls plus one long hold-off.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) rsp_stall <= 1;
         else if ($urandom_range(0, 3) == 0) rsp_stall <= 1;
         else rsp_stall <= 0;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: a selection of registers, every mode, ring behaviour, extremes.
      send_request(0, 15'h00, 0, 3'd4);
      send_request(0, 15'h28, 0, 3'd4);
      send_request(0, 15'h1000, 0, 3'd4);
      send_request(1, 15'h10, 32'h8000_0000, 0);
      send_request(0, 15'h60, 0, 3'd7);
      send_request(1, 15'h10, 32'h0000_0030, 0);
      send_request(1, 15'h60, 32'hffff_ffff, 0);
      send_request(1, 15'h7fff, 32'h0000_00a5, 0);
      send_request(0, 15'h24, 0, 3'd4);
      send_request(0, 15'h1ffc, 0, 3'd3);
      send_request(1, 15'h04, 32'hffff_ffff, 0);
      send_request(1, 15'h00, 32'h0000_0200, 0);
      send_request(1, 15'hec, 0, 0);
      send_request(0, 15'h24, 0, 0);
      send_request(1, 15'h00, 32'h0000_0100, 0);
      send_request(1, 15'h1000, 32'h5a, 0);
      send_request(0, 15'h1000, 0, 3'd2);
      send_request(1, 15'h00, 32'hffff_ffff, 0);
      send_request(1, 15'h60, 0, 0);
      send_request(1, 15'h20, 0, 0);
      send_request(0, 15'h54, 0, 3'd4);
      send_request(1, 15'h100, 1, 0);
      send_request(0, 15'h02, 0, 3'd4);
      send_request(1, 15'h10, 0, 0);
      send_request(1, 15'h00, 0, 0);
      // Fill the ring past full to provoke overflow.
      send_request(1, 15'h10, 1, 0);
      for (int i = 0; i < 260; i++) send_request(1, 15'h1000, $urandom, 0);
      send_request(1, 15'h08, 0, 0);
      for (int i = 0; i < 220; i++) begin
         if (i == 80) begin
            hold_off = 1;
            fork
               begin
                  repeat (200) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         if (i == 160) begin
            req_valid <= 0;
            @(posedge clock);
            wait (responses_due == 0);
         end
         random_gap();
         random_access();
      end
      req_valid <= 0;
      stimulus_done = 1;
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (stimulus_done && responses_due == 0) begin
            repeat (20) @(posedge clock);
            if (error_count == 0) $display("Testbench completed without errors");
            else $display("Testbench completed WITH ERRORS");
            $finish;
         end else if (idle_cycles > 5000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
src/srb_pkg.sv
src/srb_front.sv
src/srb_back.sv
src/spi_master_register_block.sv
dv/srb_checker.sv
dv/testbench.sv
